// ===== src/mpwc_pkg.sv =====
// ----------------------------------------------------------------------------
// mpwc_pkg: shared definitions for the multichannel pulse window counter
// Channel count, command and result codes, sequencer states and the result
// record passed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package mpwc_pkg;

   localparam int CHANNELS = 2;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [31:0] TIMEOUT_RESET = 32'd3000;
   localparam logic [31:0] REPORT_RESET  = 32'd5000;
   localparam logic [7:0]  WINDOWS_RESET = 8'd12;

   typedef enum logic [2:0] {
      CMD_POLL       = 3'd0,
      CMD_PULSE      = 3'd1,
      CMD_READ_CLEAR = 3'd2,
      CMD_PEEK_COUNT = 3'd3,
      CMD_PEEK_TIME  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_ALARM  = 2'd0,
      KIND_WINDOW = 2'd1,
      KIND_TOTAL  = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_TIMEOUT = 2'd0,
      REG_REPORT  = 2'd1,
      REG_WINDOWS = 2'd2
   } reg_index_type;

   typedef enum logic {
      ALU_SUB = 1'b0,
      ALU_ADD = 1'b1
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALARM,
      ST_RCHK,
      ST_WIN,
      ST_TCHK,
      ST_TOT,
      ST_PULSE,
      ST_QUERY,
      ST_DONE
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  chan;
      logic [31:0] value;
      logic        last;
   } rsp_item_type;

endpackage

// ===== src/mpwc_alu.sv =====
// ----------------------------------------------------------------------------
// mpwc_alu: shared add/subtract and threshold compare
// One 32-bit adder used by the sequencer for elapsed-time checks,
// count increments and window sum accumulation.
// ----------------------------------------------------------------------------
module mpwc_alu (
   input  mpwc_pkg::alu_op_type op,
   input  logic [31:0]          a,
   input  logic [31:0]          b,
   input  logic [31:0]          thr,
   output logic [31:0]          res,
   output logic                 ge
);
   import mpwc_pkg::*;

   always_comb begin
      if (op == ALU_ADD) begin
         res = a + b;
      end else begin
         res = a - b;
      end
      ge = (res >= thr);
   end

endmodule

// ===== src/mpwc_seq.sv =====
// ----------------------------------------------------------------------------
// mpwc_seq: per-transaction sequencer and channel state
// Walks the channels one per cycle unless the output stalls, uses the shared
// ALU, holds counters and timestamps, and stages results to flag the last.
// ----------------------------------------------------------------------------
module mpwc_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_cmd,
   input  logic [2:0]            req_channel,
   input  logic [31:0]           req_now,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data,
   input  logic                  out_free,
   output logic                  push_valid,
   output mpwc_pkg::rsp_item_type push_item
);
   import mpwc_pkg::*;

   state_type             state_ff, state_in;
   logic [CH_IDX_W-1:0]   idx_ff, idx_in;
   cmd_type               cmd_ff, cmd_in;
   logic [2:0]            chan_ff, chan_in;
   logic [31:0]           now_ff, now_in;
   rsp_item_type          pend_ff, pend_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [31:0]           lrt_ff, lrt_in;
   logic [7:0]            wc_ff, wc_in;
   logic [31:0]           timeout_ff, report_ff;
   logic [7:0]            wpt_ff;

   logic [31:0]           pc_ff  [CHANNELS];
   logic [31:0]           lpt_ff [CHANNELS];
   logic [31:0]           ms_ff  [CHANNELS];

   logic [CH_IDX_W-1:0]   sel;
   logic [31:0]           pc_rd, lpt_rd, ms_rd;
   logic                  pc_we, lpt_we, ms_we;
   logic [31:0]           pc_wd, ms_wd;
   logic                  chan_ok, idx_last;
   logic                  emit, emit_ok, advance;
   rsp_item_type          new_item;
   logic [31:0]           qval;

   alu_op_type            alu_op;
   logic [31:0]           alu_a, alu_b, alu_thr, alu_res;
   logic                  alu_ge;

   mpwc_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .thr (alu_thr),
      .res (alu_res),
      .ge  (alu_ge)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign chan_ok   = ({1'b0, chan_ff} < 4'(CHANNELS));
   assign idx_last  = (idx_ff == CH_IDX_W'(CHANNELS - 1));
   assign sel       = (state_ff == ST_ALARM || state_ff == ST_WIN || state_ff == ST_TOT)
                      ? idx_ff : chan_ff[CH_IDX_W-1:0];
   assign pc_rd     = pc_ff[sel];
   assign lpt_rd    = lpt_ff[sel];
   assign ms_rd     = ms_ff[sel];
   assign emit_ok   = !pend_valid_ff || out_free;

   always_comb begin
      qval = 32'd0;
      if (chan_ok) begin
         case (cmd_ff)
            CMD_PEEK_TIME: qval = lpt_rd;
            default:       qval = pc_rd;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      chan_in       = chan_ff;
      now_in        = now_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      lrt_in        = lrt_ff;
      wc_in         = wc_ff;
      emit          = 1'b0;
      new_item      = '0;
      pc_we         = 1'b0;
      lpt_we        = 1'b0;
      ms_we         = 1'b0;
      pc_wd         = 32'd0;
      ms_wd         = 32'd0;
      push_valid    = 1'b0;
      push_item     = pend_ff;
      push_item.last = 1'b0;
      alu_op        = ALU_SUB;
      alu_a         = now_ff;
      alu_b         = lpt_rd;
      alu_thr       = timeout_ff;
      advance       = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in  = cmd_type'(req_cmd);
               chan_in = req_channel;
               now_in  = req_now;
               idx_in  = '0;
               unique case (cmd_type'(req_cmd)) inside
                  CMD_POLL:  state_in = ST_ALARM;
                  CMD_PULSE: state_in = ST_PULSE;
                  CMD_READ_CLEAR, CMD_PEEK_COUNT, CMD_PEEK_TIME: state_in = ST_QUERY;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_ALARM: begin
            emit     = (lpt_rd != 32'd0) && alu_ge;
            new_item = '{kind: KIND_ALARM, chan: 3'(idx_ff), value: alu_res, last: 1'b0};
            advance  = !emit || emit_ok;
            if (advance) begin
               lpt_we = emit;
               if (idx_last) begin
                  idx_in   = '0;
                  state_in = ST_RCHK;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_RCHK: begin
            alu_b   = lrt_ff;
            alu_thr = report_ff;
            if (alu_ge) begin
               lrt_in   = now_ff;
               state_in = ST_WIN;
            end else begin
               state_in = ST_TCHK;
            end
         end
         ST_WIN: begin
            alu_op   = ALU_ADD;
            alu_a    = ms_rd;
            alu_b    = pc_rd;
            emit     = 1'b1;
            new_item = '{kind: KIND_WINDOW, chan: 3'(idx_ff), value: pc_rd, last: 1'b0};
            advance  = emit_ok;
            if (advance) begin
               ms_we = 1'b1;
               ms_wd = alu_res;
               pc_we = 1'b1;
               if (idx_last) begin
                  idx_in   = '0;
                  wc_in    = wc_ff + 8'd1;
                  state_in = ST_TCHK;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_TCHK: begin
            if (wc_ff >= wpt_ff) begin
               state_in = ST_TOT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TOT: begin
            emit     = 1'b1;
            new_item = '{kind: KIND_TOTAL, chan: 3'(idx_ff), value: ms_rd, last: 1'b0};
            advance  = emit_ok;
            if (advance) begin
               ms_we = 1'b1;
               if (idx_last) begin
                  idx_in   = '0;
                  wc_in    = 8'd0;
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_PULSE: begin
            alu_op = ALU_ADD;
            alu_a  = pc_rd;
            alu_b  = 32'd1;
            if (chan_ok) begin
               pc_we  = 1'b1;
               pc_wd  = alu_res;
               lpt_we = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_QUERY: begin
            emit     = 1'b1;
            new_item = '{kind: KIND_QUERY, chan: chan_ff, value: qval, last: 1'b0};
            advance  = emit_ok;
            if (advance) begin
               pc_we    = chan_ok && (cmd_ff == CMD_READ_CLEAR);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // flush the staged result as the final one of the transaction
            if (pend_valid_ff) begin
               if (out_free) begin
                  push_valid     = 1'b1;
                  push_item.last = 1'b1;
                  pend_valid_in  = 1'b0;
                  state_in       = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // stage the new result; the one it displaces is known not to be last
      if (emit && emit_ok) begin
         push_valid    = pend_valid_ff;
         pend_in       = new_item;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         idx_ff        <= '0;
         lrt_ff        <= 32'd0;
         wc_ff         <= 8'd0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         idx_ff        <= idx_in;
         lrt_ff        <= lrt_in;
         wc_ff         <= wc_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      chan_ff <= chan_in;
      now_ff  <= now_in;
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         report_ff  <= REPORT_RESET;
         wpt_ff     <= WINDOWS_RESET;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_TIMEOUT: timeout_ff <= csr_data;
            REG_REPORT:  report_ff  <= csr_data;
            REG_WINDOWS: wpt_ff     <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            pc_ff[i]  <= 32'd0;
            lpt_ff[i] <= 32'd0;
            ms_ff[i]  <= 32'd0;
         end
      end else begin
         if (pc_we) begin
            pc_ff[sel] <= pc_wd;
         end
         if (lpt_we) begin
            lpt_ff[sel] <= now_ff;
         end
         if (ms_we) begin
            ms_ff[sel] <= ms_wd;
         end
      end
   end

endmodule

// ===== src/multichannel_pulse_window_counter.sv =====
// ----------------------------------------------------------------------------
// multichannel_pulse_window_counter: pulse counting with windows and alarms
// Counts meter pulses per channel, raises no-pulse alarms, reports window
// counts and minute totals, and answers count and timestamp queries.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per command (poll, pulse, read and clear, peek
//            count, peek last time) carrying the current tick time.
//   rsp_*  : results, none or several per transaction; rsp_last marks the
//            final result caused by a request. Pulses, quiet polls and
//            unknown commands give none.
//   csr_*  : register writes (timeout, report interval, windows per total),
//            always ready; write only while the block is idle.
// Timing: a poll walks the channels one per cycle, unless the output stalls,
//   for each of the alarm, window and total passes, the alarm and window
//   passes through the shared adder. A query answer passes through the staging
//   register and the output register to rsp_*. req_ready is low until the
//   transaction is finished.
// Stalls: results move through a one-deep staging register and the output
//   register; if both are full and rsp_ready is low, the next result waits.
// Reset: clears all counters, timestamps and the window count, and loads the
//   register defaults; no result is pending afterwards.
// ----------------------------------------------------------------------------
module multichannel_pulse_window_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [2:0]  req_channel,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_chan_out,
   output logic [31:0] rsp_value,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import mpwc_pkg::*;

   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   logic         out_free;
   logic         push_valid;
   rsp_item_type push_item;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   mpwc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_channel (req_channel),
      .req_now     (req_now),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .out_free    (out_free),
      .push_valid  (push_valid),
      .push_item   (push_item)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         rsp_item_ff <= push_item;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_item_ff.kind;
   assign rsp_chan_out = rsp_item_ff.chan;
   assign rsp_value    = rsp_item_ff.value;
   assign rsp_last     = rsp_item_ff.last;

endmodule

// ===== src/mpwc_checker.sv =====
// ----------------------------------------------------------------------------
// mpwc_checker: port-level checks for the pulse window counter
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module mpwc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_value,
   input logic        rsp_last
);
   import mpwc_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("stalled result dropped or changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in progress");

   a_query_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_QUERY) |-> rsp_last)
      else $error("query answer not marked final");

endmodule

bind multichannel_pulse_window_counter mpwc_checker u_mpwc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_kind  (rsp_kind),
   .rsp_value (rsp_value),
   .rsp_last  (rsp_last)
);
